>>> hdl/apts_pkg.sv
// shared types, kind codes and byte class helpers for the pretokenizer splitter
package apts_pkg;

    localparam logic [2:0] KIND_NEWLINE  = 3'd0;
    localparam logic [2:0] KIND_LETTER   = 3'd1;
    localparam logic [2:0] KIND_SP_DIGIT = 3'd2;
    localparam logic [2:0] KIND_DIGIT    = 3'd3;
    localparam logic [2:0] KIND_SPACE    = 3'd4;
    localparam logic [2:0] KIND_PUNCT    = 3'd5;
    localparam logic [2:0] KIND_NONE     = 3'd7;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_end;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       piece_start;
        logic [2:0] piece_kind;
        logic       stream_end;
    } out_t;

    // one request worth of results: res0 always, res1 when two_res is set
    typedef struct packed {
        logic two_res;
        out_t res0;
        out_t res1;
    } entry_t;

    function automatic logic is_nl(input logic [7:0] b);
        return (b == CHAR_LF) || (b == CHAR_CR);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CHAR_SPACE) || ((b >= 8'h09) && (b <= CHAR_CR));
    endfunction

    function automatic logic [2:0] begin_kind(input logic [7:0] b);
        logic [2:0] k;
        if (is_nl(b)) begin
            k = KIND_NEWLINE;
        end else if (is_alpha(b)) begin
            k = KIND_LETTER;
        end else if (is_digit(b)) begin
            k = KIND_DIGIT;
        end else if (is_ws(b)) begin
            k = KIND_SPACE;
        end else begin
            k = KIND_PUNCT;
        end
        return k;
    endfunction

    function automatic logic grows(input logic [2:0] kind, input logic [7:0] b);
        logic g;
        unique case (kind)
            KIND_NEWLINE: g = is_nl(b);
            KIND_LETTER:  g = is_alpha(b);
            KIND_SPACE:   g = is_ws(b) && !is_nl(b);
            KIND_PUNCT:   g = !is_alpha(b) && !is_digit(b) && !is_ws(b);
            default:      g = 1'b0;
        endcase
        return g;
    endfunction

endpackage

>>> hdl/apts_front.sv
// front end: classifies each byte, tracks the open piece and builds result entries
module apts_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  apts_pkg::in_t   s_data,
    input  logic            q_full,
    output logic            q_push,
    output apts_pkg::entry_t q_entry
);
    import apts_pkg::*;

    logic [2:0] open_kind_reg, open_kind_next;
    logic       space_held_reg, space_held_next;
    logic       has_res;
    logic       s_fire;
    logic [7:0] b;
    logic       last;
    logic [2:0] bk;
    entry_t     ent;

    assign s_ready = !q_full;
    assign s_fire  = s_valid && s_ready;
    assign b       = s_data.text_byte;
    assign last    = s_data.text_end;
    assign bk      = begin_kind(b);

    always_comb begin
        ent             = '0;
        has_res         = 1'b0;
        open_kind_next  = open_kind_reg;
        space_held_next = space_held_reg;
        if (space_held_reg) begin
            space_held_next = 1'b0;
            has_res         = 1'b1;
            ent.two_res     = 1'b1;
            ent.res0        = '{out_byte: CHAR_SPACE, piece_start: 1'b1,
                                piece_kind: KIND_SPACE, stream_end: 1'b0};
            if (is_alpha(b)) begin
                ent.res0.piece_kind = KIND_LETTER;
                ent.res1 = '{out_byte: b, piece_start: 1'b0,
                             piece_kind: KIND_LETTER, stream_end: 1'b0};
                open_kind_next = KIND_LETTER;
            end else if (is_digit(b)) begin
                ent.res0.piece_kind = KIND_SP_DIGIT;
                ent.res1 = '{out_byte: b, piece_start: 1'b0,
                             piece_kind: KIND_SP_DIGIT, stream_end: 1'b0};
                open_kind_next = KIND_NONE;
            end else if (is_ws(b) && !is_nl(b)) begin
                ent.res1 = '{out_byte: b, piece_start: 1'b0,
                             piece_kind: KIND_SPACE, stream_end: 1'b0};
                open_kind_next = KIND_SPACE;
            end else begin
                ent.res1 = '{out_byte: b, piece_start: 1'b1,
                             piece_kind: bk, stream_end: 1'b0};
                open_kind_next = (bk == KIND_DIGIT) ? KIND_NONE : bk;
            end
        end else if (grows(open_kind_reg, b)) begin
            has_res  = 1'b1;
            ent.res0 = '{out_byte: b, piece_start: 1'b0,
                         piece_kind: open_kind_reg, stream_end: 1'b0};
        end else if ((b == CHAR_SPACE) && !last) begin
            // hold the space until the next byte picks its piece
            space_held_next = 1'b1;
            open_kind_next  = KIND_NONE;
        end else begin
            has_res  = 1'b1;
            ent.res0 = '{out_byte: b, piece_start: 1'b1,
                         piece_kind: bk, stream_end: 1'b0};
            open_kind_next = (bk == KIND_DIGIT) ? KIND_NONE : bk;
        end
        if (last) begin
            if (ent.two_res) begin
                ent.res1.stream_end = 1'b1;
            end else begin
                ent.res0.stream_end = 1'b1;
            end
            open_kind_next  = KIND_NONE;
            space_held_next = 1'b0;
        end
    end

    assign q_push  = s_fire && has_res;
    assign q_entry = ent;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_kind_reg  <= KIND_NONE;
            space_held_reg <= 1'b0;
        end else if (s_fire) begin
            open_kind_reg  <= open_kind_next;
            space_held_reg <= space_held_next;
        end
    end

endmodule

>>> hdl/apts_queue.sv
// small fifo of result entries between front and back
module apts_queue #(
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  apts_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output apts_pkg::entry_t pop_entry,
    output logic             empty
);
    import apts_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    entry_t          mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> hdl/apts_back.sv
// back end: unpacks entries into single results behind an output register
module apts_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_empty,
    input  apts_pkg::entry_t q_entry,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output apts_pkg::out_t   m_data
);
    import apts_pkg::*;

    logic m_valid_reg, m_valid_next;
    out_t m_data_reg, m_data_next;
    logic pend_reg, pend_next;
    out_t pend_data_reg, pend_data_next;
    logic load_ok;

    assign load_ok = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        pend_next      = pend_reg;
        pend_data_next = pend_data_reg;
        q_pop          = 1'b0;
        if (load_ok) begin
            if (pend_reg) begin
                // second result of the last entry goes out first
                m_valid_next = 1'b1;
                m_data_next  = pend_data_reg;
                pend_next    = 1'b0;
            end else if (!q_empty) begin
                q_pop          = 1'b1;
                m_valid_next   = 1'b1;
                m_data_next    = q_entry.res0;
                pend_next      = q_entry.two_res;
                pend_data_next = q_entry.res1;
            end else begin
                m_valid_next = 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        pend_data_reg <= pend_data_next;
    end

endmodule

>>> hdl/ascii_pretokenizer_splitter_unit.sv
// top level of the ascii pretokenizer splitter: front, result queue and back
// path: a byte's results wait in the QUEUE_DEPTH queue, then in the output register
// throughput: one byte per cycle in while the queue has room, one result per cycle out
// with m_ready high; a held space and its follower leave as two results via the queue
// reset: aresetn low clears piece state, queue pointers and output valid
module ascii_pretokenizer_splitter_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  apts_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output apts_pkg::out_t m_data
);
    import apts_pkg::*;

    logic   q_full, q_push, q_pop, q_empty;
    entry_t push_entry, pop_entry;

    apts_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (push_entry)
    );

    apts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .empty      (q_empty)
    );

    apts_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_entry (pop_entry),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> hdl/apts_checker.sv
// port-level checks for the pretokenizer splitter, bound to the top level
module apts_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input apts_pkg::in_t  s_data,
    input logic           m_valid,
    input logic           m_ready,
    input apts_pkg::out_t m_data
);
    import apts_pkg::*;

    // a waiting request holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("request changed while waiting");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // nothing comes out right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a lone digit always opens its own piece
    a_digit_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.piece_kind == KIND_DIGIT) |-> m_data.piece_start)
        else $error("digit result without piece start");

    // only spaces open a space-digit piece
    a_spdigit_space: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.piece_kind == KIND_SP_DIGIT) && m_data.piece_start
        |-> (m_data.out_byte == CHAR_SPACE))
        else $error("space-digit piece not opened by a space");

endmodule

bind ascii_pretokenizer_splitter_unit apts_checker u_apts_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

>>> sim/tb_ascii_pretokenizer_splitter_unit.sv
// testbench for the ascii pretokenizer splitter: directed byte rows, then random texts
`timescale 1ns / 100ps

module tb_ascii_pretokenizer_splitter_unit;
    import apts_pkg::*;

    typedef enum logic [2:0] {
        CL_NL, CL_ALPHA, CL_DIGIT, CL_SPACE, CL_WS, CL_OTHER
    } char_class_t;

    // pieces typed in by hand for a directed row; typed == 0 leaves it to the predictor
    typedef struct packed {
        bit         typed;
        logic [1:0] n;
        out_t       r0;
        out_t       r1;
    } typed_result_t;

    typedef struct packed {
        in_t           req;
        typed_result_t chk;
    } dir_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    // splitter state as the predictor sees it
    logic [2:0] run_kind = KIND_NONE;
    bit         space_pending = 1'b0;

    out_t          expected_pieces[$];
    typed_result_t typed_pieces[$];
    dir_row_t      dir_rows[$];

    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int bytes_taken = 0;
    int texts_taken = 0;
    int pieces_seen = 0;
    int pairs_predicted = 0;
    int kind_seen[8];

    ascii_pretokenizer_splitter_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic char_class_t char_class(input logic [7:0] ch);
        char_class_t c;
        if (ch == CHAR_LF || ch == CHAR_CR) begin
            c = CL_NL;
        end else if ((ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z")) begin
            c = CL_ALPHA;
        end else if (ch >= "0" && ch <= "9") begin
            c = CL_DIGIT;
        end else if (ch == CHAR_SPACE) begin
            c = CL_SPACE;
        end else if (ch >= 8'h09 && ch <= 8'h0D) begin
            c = CL_WS;
        end else begin
            c = CL_OTHER;
        end
        return c;
    endfunction

    function automatic logic [2:0] opening_kind(input char_class_t c);
        logic [2:0] k;
        case (c)
            CL_NL:    k = KIND_NEWLINE;
            CL_ALPHA: k = KIND_LETTER;
            CL_DIGIT: k = KIND_DIGIT;
            CL_OTHER: k = KIND_PUNCT;
            default:  k = KIND_SPACE;
        endcase
        return k;
    endfunction

    function automatic bit extends_run(input logic [2:0] k, input char_class_t c);
        bit g;
        case (k)
            KIND_NEWLINE: g = (c == CL_NL);
            KIND_LETTER:  g = (c == CL_ALPHA);
            KIND_SPACE:   g = (c == CL_SPACE) || (c == CL_WS);
            KIND_PUNCT:   g = (c == CL_OTHER);
            default:      g = 1'b0;
        endcase
        return g;
    endfunction

    function automatic out_t piece(input logic [7:0] ch, input logic start,
                                   input logic [2:0] k, input logic fin);
        out_t p;
        p.out_byte    = ch;
        p.piece_start = start;
        p.piece_kind  = k;
        p.stream_end  = fin;
        return p;
    endfunction

    // predicts the pieces one accepted byte releases and advances the run state
    function automatic int split_byte(input in_t req, output out_t r0, output out_t r1);
        char_class_t c;
        logic [7:0]  ch;
        logic [2:0]  k;
        int          n;
        ch = req.text_byte;
        c = char_class(ch);
        n = 0;
        r0 = '0;
        r1 = '0;
        if (space_pending) begin
            space_pending = 1'b0;
            n = 2;
            if (c == CL_ALPHA) begin
                r0 = piece(CHAR_SPACE, 1'b1, KIND_LETTER, 1'b0);
                r1 = piece(ch, 1'b0, KIND_LETTER, 1'b0);
                run_kind = KIND_LETTER;
            end else if (c == CL_DIGIT) begin
                r0 = piece(CHAR_SPACE, 1'b1, KIND_SP_DIGIT, 1'b0);
                r1 = piece(ch, 1'b0, KIND_SP_DIGIT, 1'b0);
                run_kind = KIND_NONE;
            end else if (c == CL_SPACE || c == CL_WS) begin
                r0 = piece(CHAR_SPACE, 1'b1, KIND_SPACE, 1'b0);
                r1 = piece(ch, 1'b0, KIND_SPACE, 1'b0);
                run_kind = KIND_SPACE;
            end else begin
                k = opening_kind(c);
                r0 = piece(CHAR_SPACE, 1'b1, KIND_SPACE, 1'b0);
                r1 = piece(ch, 1'b1, k, 1'b0);
                run_kind = k;
            end
        end else if (extends_run(run_kind, c)) begin
            r0 = piece(ch, 1'b0, run_kind, 1'b0);
            n = 1;
        end else if (c == CL_SPACE && !req.text_end) begin
            space_pending = 1'b1;
            run_kind = KIND_NONE;
        end else begin
            k = opening_kind(c);
            r0 = piece(ch, 1'b1, k, 1'b0);
            run_kind = (k == KIND_DIGIT) ? KIND_NONE : k;
            n = 1;
        end
        if (req.text_end) begin
            if (n == 2) begin
                r1.stream_end = 1'b1;
            end else if (n == 1) begin
                r0.stream_end = 1'b1;
            end
            run_kind = KIND_NONE;
            space_pending = 1'b0;
        end
        return n;
    endfunction

    function automatic logic [7:0] text_char();
        string punct = "!\"#$%&'()*+,-./:;<=>?@[\\]^_{|}~";
        int    pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            return 8'(($urandom_range(0, 1) ? 65 : 97) + $urandom_range(0, 25));
        end else if (pick < 45) begin
            return CHAR_SPACE;
        end else if (pick < 55) begin
            return 8'(48 + $urandom_range(0, 9));
        end else if (pick < 63) begin
            return 8'(punct[$urandom_range(0, punct.len() - 1)]);
        end else if (pick < 68) begin
            return $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
        end else if (pick < 73) begin
            return 8'($urandom_range(9, 13));
        end else if (pick < 80) begin
            return 8'($urandom_range(128, 255));
        end else if (pick < 85) begin
            return 8'($urandom_range(0, 31));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void add_row(input logic [7:0] ch, input logic fin, input bit typed,
                                    input int n, input out_t r0, input out_t r1);
        dir_row_t row;
        row.req.text_byte = ch;
        row.req.text_end  = fin;
        row.chk.typed     = typed;
        row.chk.n         = 2'(n);
        row.chk.r0        = r0;
        row.chk.r1        = r1;
        dir_rows = {dir_rows, row};
    endfunction

    // drives one request and returns at the edge that takes it
    task automatic send_req(input in_t req, input typed_result_t chk);
        while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        typed_pieces = {typed_pieces, chk};
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // prediction on the input side first, then checking, so one block owns the queue
    always @(posedge aclk) begin : scoreboard
        typed_result_t chk;
        out_t          p0;
        out_t          p1;
        out_t          want;
        int            n;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                chk = typed_pieces.pop_front();
                n = split_byte(s_data, p0, p1);
                if (chk.typed) begin
                    n  = chk.n;
                    p0 = chk.r0;
                    p1 = chk.r1;
                end
                if (n > 0) expected_pieces = {expected_pieces, p0};
                if (n > 1) expected_pieces = {expected_pieces, p1};
                if (n == 2) pairs_predicted++;
                bytes_taken++;
                if (s_data.text_end) texts_taken++;
            end
            if (m_valid && m_ready) begin
                pieces_seen++;
                kind_seen[m_data.piece_kind]++;
                if (expected_pieces.size() == 0) begin
                    $error("unexpected piece: out_byte %h piece_start %b piece_kind %0d",
                           m_data.out_byte, m_data.piece_start, m_data.piece_kind);
                    mismatch_count++;
                end else begin
                    want = expected_pieces.pop_front();
                    if (m_data.out_byte !== want.out_byte) begin
                        $error("out_byte expected %h actual %h", want.out_byte, m_data.out_byte);
                        mismatch_count++;
                    end
                    if (m_data.piece_start !== want.piece_start) begin
                        $error("piece_start expected %b actual %b",
                               want.piece_start, m_data.piece_start);
                        mismatch_count++;
                    end
                    if (m_data.piece_kind !== want.piece_kind) begin
                        $error("piece_kind expected %0d actual %0d",
                               want.piece_kind, m_data.piece_kind);
                        mismatch_count++;
                    end
                    if (m_data.stream_end !== want.stream_end) begin
                        $error("stream_end expected %b actual %b",
                               want.stream_end, m_data.stream_end);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial begin
        in_t           req;
        typed_result_t no_check;
        int            gap_by_phase[4];
        int            stall_by_phase[4];
        int            sent_in_phase;
        int            len;

        no_check = '0;
        gap_by_phase   = '{0, 45, 0, 26};
        stall_by_phase = '{0, 0, 45, 26};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows: letter runs, held spaces before every class, extremes, text ends
        add_row(8'h41, 1'b0, 1'b1, 1, piece(8'h41, 1'b1, KIND_LETTER, 1'b0), '0);
        add_row(8'h7A, 1'b0, 1'b0, 0, '0, '0);
        add_row(CHAR_SPACE, 1'b0, 1'b0, 0, '0, '0);
        add_row(8'h62, 1'b0, 1'b0, 0, '0, '0);
        add_row(CHAR_SPACE, 1'b0, 1'b0, 0, '0, '0);
        add_row(8'h30, 1'b0, 1'b0, 0, '0, '0);
        add_row(8'h39, 1'b0, 1'b0, 0, '0, '0);
        add_row(CHAR_SPACE, 1'b0, 1'b0, 0, '0, '0);
        add_row(8'h09, 1'b0, 1'b0, 0, '0, '0);
        add_row(CHAR_SPACE, 1'b0, 1'b0, 0, '0, '0);
        add_row(CHAR_LF, 1'b0, 1'b0, 0, '0, '0);
        add_row(CHAR_CR, 1'b0, 1'b0, 0, '0, '0);
        add_row(CHAR_SPACE, 1'b0, 1'b0, 0, '0, '0);
        add_row(CHAR_LF, 1'b0, 1'b0, 0, '0, '0);
        add_row(CHAR_SPACE, 1'b0, 1'b0, 0, '0, '0);
        add_row(8'h21, 1'b0, 1'b0, 0, '0, '0);
        add_row(8'hFF, 1'b0, 1'b1, 1, piece(8'hFF, 1'b0, KIND_PUNCT, 1'b0), '0);
        add_row(8'h00, 1'b0, 1'b1, 1, piece(8'h00, 1'b0, KIND_PUNCT, 1'b0), '0);
        add_row(8'h80, 1'b0, 1'b0, 0, '0, '0);
        // a space as the last byte with nothing held stands alone
        add_row(CHAR_SPACE, 1'b1, 1'b1, 1, piece(CHAR_SPACE, 1'b1, KIND_SPACE, 1'b1), '0);
        add_row(CHAR_SPACE, 1'b0, 1'b0, 0, '0, '0);
        add_row(8'h5A, 1'b1, 1'b0, 0, '0, '0);
        add_row(CHAR_SPACE, 1'b0, 1'b0, 0, '0, '0);
        add_row(CHAR_SPACE, 1'b1, 1'b0, 0, '0, '0);
        add_row(8'h30, 1'b1, 1'b1, 1, piece(8'h30, 1'b1, KIND_DIGIT, 1'b1), '0);

        foreach (dir_rows[i]) begin
            send_req(dir_rows[i].req, dir_rows[i].chk);
        end

        for (int ph = 0; ph < 4; ph++) begin
            send_gap_pct   = gap_by_phase[ph];
            recv_stall_pct = stall_by_phase[ph];
            sent_in_phase  = 0;
            while (sent_in_phase < 450) begin
                if ($urandom_range(0, 9) == 0) begin
                    // noise: any byte, any end flag
                    req.text_byte = 8'($urandom_range(0, 255));
                    req.text_end  = 1'($urandom_range(0, 1));
                    send_req(req, no_check);
                    sent_in_phase++;
                end else begin
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 24);
                    for (int i = 0; i < len; i++) begin
                        req.text_byte = text_char();
                        req.text_end  = (i == len - 1);
                        send_req(req, no_check);
                        sent_in_phase++;
                    end
                end
            end
        end
        s_valid <= 1'b0;

        while (expected_pieces.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("covered %0d bytes in %0d texts, %0d pieces checked, %0d space pairs",
                 bytes_taken, texts_taken, pieces_seen, pairs_predicted);
        $display("pieces by kind: nl %0d letter %0d sp-digit %0d digit %0d ws %0d punct %0d",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
                 kind_seen[5]);
        if (mismatch_count == 0 && typed_pieces.size() == 0) begin
            $display("tb_ascii_pretokenizer_splitter_unit passed");
        end else begin
            $display("tb_ascii_pretokenizer_splitter_unit failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_ascii_pretokenizer_splitter_unit failed");
        $finish;
    end

endmodule

>>> ascii_pretokenizer_splitter_unit.f
hdl/apts_pkg.sv
hdl/apts_front.sv
hdl/apts_queue.sv
hdl/apts_back.sv
hdl/ascii_pretokenizer_splitter_unit.sv
hdl/apts_checker.sv
sim/tb_ascii_pretokenizer_splitter_unit.sv
